@@ rtl/core/srs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sweep range scan package
// Shared types, register codes and constants of the sweep range scan
// sequencer.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int unsigned StepCountDef = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned SampleIdxW   = 4;
  localparam int unsigned ServoCenterDeg = 90;
  localparam int unsigned MinValidMm     = 10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MOVE_TIME     = 3'd0,
    CFG_RETRY_DELAY   = 3'd1,
    CFG_RETRY_LIMIT   = 3'd2,
    CFG_STEP_ANGLE    = 3'd3,
    CFG_ANGLE_MIN     = 3'd4,
    CFG_ANGLE_MAX     = 3'd5,
    CFG_CENTER_OFFSET = 3'd6
  } cfg_idx_e;

  localparam logic [15:0]        MoveTimeRst     = 16'd500;
  localparam logic [15:0]        RetryDelayRst   = 16'd10;
  localparam logic [3:0]         RetryLimitRst   = 4'd3;
  localparam logic [4:0]         StepAngleRst    = 5'd10;
  localparam logic signed [7:0]  AngleMinRst     = -8'sd90;
  localparam logic [6:0]         AngleMaxRst     = 7'd90;
  localparam logic signed [5:0]  CenterOffRst    = 6'sd0;

  typedef struct packed {
    logic [15:0]       move_time_ms;
    logic [15:0]       retry_delay_ms;
    logic [3:0]        retry_limit;
    logic [4:0]        step_angle_deg;
    logic signed [7:0] angle_min_deg;
    logic [6:0]        angle_max_deg;
    logic signed [5:0] center_offset_deg;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] now_ms;
    logic [15:0] distance_mm;
    logic [7:0]  read_index;
  } item_t;

  typedef struct packed {
    logic                  accepted;
    logic                  servo_write;
    logic [7:0]            servo_position;
    logic                  sample_written;
    logic [SampleIdxW-1:0] sample_index;
    logic [15:0]           sample_mm;
    logic                  running;
    logic                  done_res;
    logic [3:0]            retry_count;
    logic [15:0]           update_delay_ms;
    logic [15:0]           read_distance_mm;
  } res_t;

endpackage

@@ rtl/core/sweep_range_scan_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sweep range scan sequencer
// Runs a servo sweep over the scan steps, stores one distance per step and
// retries readings that are too small.
//
// Usage: a beat on the input channel is either a start (mode high) or a time
// beat carrying the millisecond count, a distance reading and a table read
// index. Every input beat produces exactly one result beat, which says
// whether it caused an action, any servo command and stored sample, the
// sweep status and the stored distance at the read index.
// The accepting edge loads the input register, and a later edge loads the
// result register through the sequencing logic once it is free of a stalled
// beat. One beat is taken per cycle while the receiver does not stall.
// Configuration must be written through the plain write port while no beat
// is in flight; the block does not check. Reset loads the default settings,
// clears the sweep state and the distance table and empties both registers.
// When the receiver stalls, the result register holds its beat; the input
// register fills next, and in_stall_o rises only while both are full.
// ----------------------------------------------------------------------------
module sweep_range_scan_sequencer_top #(
  parameter int unsigned StepCount = srs_pkg::StepCountDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [srs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [srs_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [31:0]                  now_ms_i,
  input  logic [15:0]                  distance_mm_i,
  input  logic [7:0]                   read_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         accepted_o,
  output logic                         servo_write_o,
  output logic [7:0]                   servo_position_o,
  output logic                         sample_written_o,
  output logic [srs_pkg::SampleIdxW-1:0] sample_index_o,
  output logic [15:0]                  sample_mm_o,
  output logic                         running_o,
  output logic                         done_res_o,
  output logic [3:0]                   retry_count_o,
  output logic [15:0]                  update_delay_ms_o,
  output logic [15:0]                  read_distance_mm_o
);
  import srs_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  res_t  res;
  res_t  res_q;
  logic  item_valid_q, item_valid_d;
  logic  out_valid_q, out_valid_d;
  logic  step_en;
  logic  in_take;

  srs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign step_en    = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !step_en;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_take) begin
      item_valid_d = 1'b1;
    end else if (step_en) begin
      item_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step_en) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.mode        <= mode_i;
      item_q.now_ms      <= now_ms_i;
      item_q.distance_mm <= distance_mm_i;
      item_q.read_index  <= read_index_i;
    end
    if (step_en) begin
      res_q <= res;
    end
  end

  srs_seq_core #(
    .StepCount (StepCount)
  ) u_seq_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign out_valid_o        = out_valid_q;
  assign accepted_o         = res_q.accepted;
  assign servo_write_o      = res_q.servo_write;
  assign servo_position_o   = res_q.servo_position;
  assign sample_written_o   = res_q.sample_written;
  assign sample_index_o     = res_q.sample_index;
  assign sample_mm_o        = res_q.sample_mm;
  assign running_o          = res_q.running;
  assign done_res_o         = res_q.done_res;
  assign retry_count_o      = res_q.retry_count;
  assign update_delay_ms_o  = res_q.update_delay_ms;
  assign read_distance_mm_o = res_q.read_distance_mm;

endmodule

@@ rtl/core/srs_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sweep range scan configuration registers
// Holds the timing, retry and angle settings written through the plain
// write port.
// ----------------------------------------------------------------------------
module srs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [srs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output srs_pkg::cfg_t                 cfg_o
);
  import srs_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.move_time_ms      <= MoveTimeRst;
      cfg_q.retry_delay_ms    <= RetryDelayRst;
      cfg_q.retry_limit       <= RetryLimitRst;
      cfg_q.step_angle_deg    <= StepAngleRst;
      cfg_q.angle_min_deg     <= AngleMinRst;
      cfg_q.angle_max_deg     <= AngleMaxRst;
      cfg_q.center_offset_deg <= CenterOffRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MOVE_TIME:     cfg_q.move_time_ms      <= cfg_wdata_i[15:0];
        CFG_RETRY_DELAY:   cfg_q.retry_delay_ms    <= cfg_wdata_i[15:0];
        CFG_RETRY_LIMIT:   cfg_q.retry_limit       <= cfg_wdata_i[3:0];
        CFG_STEP_ANGLE:    cfg_q.step_angle_deg    <= cfg_wdata_i[4:0];
        CFG_ANGLE_MIN:     cfg_q.angle_min_deg     <= $signed(cfg_wdata_i[7:0]);
        CFG_ANGLE_MAX:     cfg_q.angle_max_deg     <= cfg_wdata_i[6:0];
        CFG_CENTER_OFFSET: cfg_q.center_offset_deg <= $signed(cfg_wdata_i[5:0]);
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/srs_servo_cmd.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sweep range scan servo command
// Turns a step position into a clamped, mirrored and trimmed 8-bit servo
// command.
// ----------------------------------------------------------------------------
module srs_servo_cmd #(
  parameter int unsigned StepCount = srs_pkg::StepCountDef,
  parameter int unsigned PosW      = $clog2(StepCount + 1) + 1
) (
  input  logic signed [PosW-1:0] idx_i,
  input  srs_pkg::cfg_t          cfg_i,
  output logic [7:0]             pos_o
);
  import srs_pkg::*;

  localparam logic [7:0] Half = 8'(StepCount / 2);

  logic [7:0]        diff;
  logic [15:0]       prod;
  logic signed [8:0] ang;
  logic signed [8:0] hi;
  logic signed [8:0] lo;
  logic signed [8:0] ang_clamped;
  logic signed [9:0] cmd;

  always_comb begin
    diff = 8'(idx_i) - Half;
    prod = {8'b0, diff} * {11'b0, cfg_i.step_angle_deg};
    ang  = $signed({prod[7], prod[7:0]});
    hi   = $signed({2'b00, cfg_i.angle_max_deg});
    lo   = $signed({cfg_i.angle_min_deg[7], cfg_i.angle_min_deg});
    ang_clamped = ang;
    if (ang_clamped > hi) begin
      ang_clamped = hi;
    end
    if (ang_clamped < lo) begin
      ang_clamped = lo;
    end
    cmd = $signed(10'(ServoCenterDeg)) - {ang_clamped[8], ang_clamped}
        + {{4{cfg_i.center_offset_deg[5]}}, cfg_i.center_offset_deg};
    pos_o = cmd[7:0];
  end

endmodule

@@ rtl/core/srs_dist_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sweep range scan distance table
// One stored distance per sweep step, with a read port that sees a write
// made in the same cycle.
// ----------------------------------------------------------------------------
module srs_dist_table #(
  parameter int unsigned StepCount = srs_pkg::StepCountDef,
  parameter int unsigned IdxW      = $clog2(StepCount)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [15:0]     wdata_i,
  input  logic [7:0]      raddr_i,
  output logic [15:0]     rdata_o
);

  logic [15:0] mem_q [StepCount];
  logic        in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StepCount; i++) begin
        mem_q[i] <= '0;
      end
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_comb begin
    in_range = raddr_i < 8'(StepCount);
    if (!in_range) begin
      rdata_o = '0;
    end else if (we_i && (waddr_i == raddr_i[IdxW-1:0])) begin
      rdata_o = wdata_i;
    end else begin
      rdata_o = mem_q[raddr_i[IdxW-1:0]];
    end
  end

endmodule

@@ rtl/core/srs_seq_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sweep range scan sequencer core
// Holds the sweep state and works out one result beat per stepped item.
// ----------------------------------------------------------------------------
module srs_seq_core #(
  parameter int unsigned StepCount = srs_pkg::StepCountDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_en_i,
  input  srs_pkg::item_t item_i,
  input  srs_pkg::cfg_t  cfg_i,
  output srs_pkg::res_t  res_o
);
  import srs_pkg::*;

  localparam int unsigned PosW = $clog2(StepCount + 1) + 1;
  localparam int unsigned IdxW = $clog2(StepCount);
  localparam logic signed [PosW-1:0] PosLast = PosW'(StepCount - 1);
  localparam logic signed [PosW-1:0] PosEnd  = PosW'(StepCount);

  logic                   running_q, running_d;
  logic                   done_q, done_d;
  logic                   reverse_q, reverse_d;
  logic                   first_q, first_d;
  logic signed [PosW-1:0] pos_q, pos_d;
  logic [31:0]            due_q, due_d;
  logic [3:0]             retries_q, retries_d;
  logic [15:0]            late_q, late_d;

  logic signed [PosW-1:0] pos_step;
  logic signed [PosW-1:0] cmd_idx;
  logic [7:0]             cmd_pos;
  logic [32:0]            elapsed;
  logic                   tbl_we;
  logic [15:0]            tbl_wdata;
  logic [15:0]            tbl_rdata;
  logic                   ended;

  assign pos_step = reverse_q ? pos_q - PosW'(1) : pos_q + PosW'(1);
  assign cmd_idx  = first_q ? pos_q : pos_step;
  assign elapsed  = {1'b0, item_i.now_ms} - {1'b0, due_q};
  assign ended    = reverse_q ? pos_step[PosW-1] : (pos_step >= PosEnd);

  srs_servo_cmd #(
    .StepCount (StepCount),
    .PosW      (PosW)
  ) u_servo_cmd (
    .idx_i (cmd_idx),
    .cfg_i (cfg_i),
    .pos_o (cmd_pos)
  );

  srs_dist_table #(
    .StepCount (StepCount),
    .IdxW      (IdxW)
  ) u_dist_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (step_en_i && tbl_we),
    .waddr_i (pos_q[IdxW-1:0]),
    .wdata_i (tbl_wdata),
    .raddr_i (item_i.read_index),
    .rdata_o (tbl_rdata)
  );

  always_comb begin
    running_d = running_q;
    done_d    = done_q;
    reverse_d = reverse_q;
    first_d   = first_q;
    pos_d     = pos_q;
    due_d     = due_q;
    retries_d = retries_q;
    late_d    = late_q;
    tbl_we    = 1'b0;
    tbl_wdata = (retries_q >= cfg_i.retry_limit) ? 16'd0 : item_i.distance_mm;
    res_o     = '0;

    if (item_i.mode) begin
      running_d = 1'b1;
      done_d    = 1'b0;
      retries_d = '0;
      if (!reverse_q && (pos_q >= PosLast)) begin
        pos_d     = PosLast;
        reverse_d = 1'b1;
      end else begin
        pos_d     = '0;
        reverse_d = 1'b0;
      end
      first_d        = 1'b1;
      due_d          = '0;
      res_o.accepted = 1'b1;
    end else if (running_q) begin
      if (first_q) begin
        first_d              = 1'b0;
        res_o.servo_write    = 1'b1;
        res_o.servo_position = cmd_pos;
        due_d                = item_i.now_ms + 32'(cfg_i.move_time_ms);
        res_o.accepted       = 1'b1;
      end else if (!elapsed[32]) begin
        late_d         = (|elapsed[31:16]) ? 16'hFFFF : elapsed[15:0];
        res_o.accepted = 1'b1;
        if ((item_i.distance_mm < 16'(MinValidMm)) &&
            (retries_q < cfg_i.retry_limit)) begin
          due_d     = item_i.now_ms + 32'(cfg_i.retry_delay_ms);
          retries_d = retries_q + 4'd1;
        end else begin
          tbl_we               = !pos_q[PosW-1] && (pos_q < PosEnd);
          res_o.sample_written = 1'b1;
          res_o.sample_index   = SampleIdxW'(pos_q);
          res_o.sample_mm      = tbl_wdata;
          pos_d                = pos_step;
          due_d                = item_i.now_ms + 32'(cfg_i.move_time_ms);
          if (ended) begin
            running_d = 1'b0;
            done_d    = 1'b1;
          end else begin
            res_o.servo_write    = 1'b1;
            res_o.servo_position = cmd_pos;
          end
        end
      end
    end

    res_o.running          = running_d;
    res_o.done_res         = done_d;
    res_o.retry_count      = retries_d;
    res_o.update_delay_ms  = late_d;
    res_o.read_distance_mm = tbl_rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      reverse_q <= 1'b0;
      first_q   <= 1'b0;
      pos_q     <= '0;
      due_q     <= '0;
      retries_q <= '0;
      late_q    <= '0;
    end else if (step_en_i) begin
      running_q <= running_d;
      done_q    <= done_d;
      reverse_q <= reverse_d;
      first_q   <= first_d;
      pos_q     <= pos_d;
      due_q     <= due_d;
      retries_q <= retries_d;
      late_q    <= late_d;
    end
  end

endmodule

@@ rtl/core/srs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sweep range scan checker
// Port-level checks on the result beats of the sweep range scan sequencer.
// ----------------------------------------------------------------------------
module srs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        accepted_o,
  input logic        servo_write_o,
  input logic [7:0]  servo_position_o,
  input logic        sample_written_o,
  input logic [15:0] sample_mm_o,
  input logic        running_o,
  input logic        done_res_o,
  input logic [15:0] read_distance_mm_o
);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(servo_position_o)
      && $stable(sample_mm_o) && $stable(read_distance_mm_o))
    else $error("Stalled result beat changed.");

  a_action_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (servo_write_o || sample_written_o) |-> accepted_o)
    else $error("Action reported on a beat that was not accepted.");

  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !running_o)
    else $error("Sweep reported done and running together.");

  a_move_while_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && servo_write_o |-> running_o)
    else $error("Servo commanded outside a running sweep.");

  a_idle_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !servo_write_o |-> servo_position_o == 8'd0)
    else $error("Servo position set without a servo command.");

endmodule

bind sweep_range_scan_sequencer_top srs_checker u_srs_checker (.*);

@@ sim/tb_sweep_range_scan_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sweep range scan sequencer testbench
// Drives start and time beats into the sequencer under several register
// settings and idle patterns. A behavioral copy of the sweep logic predicts
// every result beat, and each one is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_sweep_range_scan_sequencer_top;
  import srs_pkg::*;

  localparam int          Steps       = int'(StepCountDef);
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned DrainCycles = 8;

  typedef enum int {
    SET_DEFAULT,
    SET_FAST_WIDE,
    SET_SLOW_NARROW,
    SET_RANDOM,
    SET_RAW
  } setting_e;

  logic                     clk;
  logic                     rst_n            = 1'b0;
  logic                     cfg_we           = 1'b0;
  cfg_idx_e                 cfg_index        = CFG_MOVE_TIME;
  logic [CfgDataW-1:0]      cfg_wdata        = '0;
  logic                     in_valid         = 1'b0;
  logic                     in_stall;
  logic                     mode             = 1'b0;
  logic [31:0]              now_ms           = '0;
  logic [15:0]              distance_mm      = '0;
  logic [7:0]               read_index       = '0;
  logic                     out_valid;
  logic                     out_stall        = 1'b0;
  logic                     accepted;
  logic                     servo_write;
  logic [7:0]               servo_position;
  logic                     sample_written;
  logic [SampleIdxW-1:0]    sample_index;
  logic [15:0]              sample_mm;
  logic                     running;
  logic                     done_res;
  logic [3:0]               retry_count;
  logic [15:0]              update_delay_ms;
  logic [15:0]              read_distance_mm;

  cfg_t                     scan_cfg;
  bit                       sc_running;
  bit                       sc_done;
  bit                       sc_reverse;
  int                       sc_step;
  bit                       sc_first;
  logic [31:0]              sc_due;
  logic [3:0]               sc_retries;
  logic [15:0]              sc_late;
  logic [15:0]              sc_table [Steps];

  res_t                     expected_results [$];
  int unsigned              errors          = 0;
  int unsigned              send_idle_pct   = 0;
  int unsigned              recv_idle_pct   = 0;
  bit                       hold_request    = 1'b0;
  int unsigned              hold_left       = 0;
  int unsigned              quiet_cycles    = 0;
  int unsigned              raw_uses        = 0;
  int unsigned              sent_beats      = 0;
  int unsigned              acted_beats     = 0;
  int unsigned              stored_samples  = 0;
  int unsigned              finished_sweeps = 0;
  int unsigned              backward_sweeps = 0;
  int unsigned              retried_beats   = 0;

  sweep_range_scan_sequencer_top dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .mode_i             (mode),
    .now_ms_i           (now_ms),
    .distance_mm_i      (distance_mm),
    .read_index_i       (read_index),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .accepted_o         (accepted),
    .servo_write_o      (servo_write),
    .servo_position_o   (servo_position),
    .sample_written_o   (sample_written),
    .sample_index_o     (sample_index),
    .sample_mm_o        (sample_mm),
    .running_o          (running),
    .done_res_o         (done_res),
    .retry_count_o      (retry_count),
    .update_delay_ms_o  (update_delay_ms),
    .read_distance_mm_o (read_distance_mm)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void scan_reset();
    scan_cfg.move_time_ms      = MoveTimeRst;
    scan_cfg.retry_delay_ms    = RetryDelayRst;
    scan_cfg.retry_limit       = RetryLimitRst;
    scan_cfg.step_angle_deg    = StepAngleRst;
    scan_cfg.angle_min_deg     = AngleMinRst;
    scan_cfg.angle_max_deg     = AngleMaxRst;
    scan_cfg.center_offset_deg = CenterOffRst;
    sc_running = 1'b0;
    sc_done    = 1'b0;
    sc_reverse = 1'b0;
    sc_step    = 0;
    sc_first   = 1'b0;
    sc_due     = '0;
    sc_retries = '0;
    sc_late    = '0;
    foreach (sc_table[i]) sc_table[i] = '0;
  endfunction

  function automatic logic [7:0] servo_angle(int idx);
    logic [7:0] raw;
    int         ang;
    int         lo;
    int         hi;
    int         cmd;
    raw = 8'(idx * int'(scan_cfg.step_angle_deg) - (Steps / 2) * int'(scan_cfg.step_angle_deg));
    ang = int'($signed(raw));
    lo  = int'($signed(scan_cfg.angle_min_deg));
    hi  = int'(scan_cfg.angle_max_deg);
    if (ang > hi) ang = hi;
    if (ang < lo) ang = lo;
    cmd = int'(ServoCenterDeg) - ang + int'($signed(scan_cfg.center_offset_deg));
    return 8'(cmd);
  endfunction

  function automatic res_t scan_predict(item_t it);
    res_t        r;
    logic [31:0] gap;
    logic [15:0] val;
    r = '0;
    if (it.mode) begin
      sc_running = 1'b1;
      sc_done    = 1'b0;
      sc_retries = '0;
      if (!sc_reverse && sc_step >= Steps - 1) begin
        sc_step    = Steps - 1;
        sc_reverse = 1'b1;
        backward_sweeps++;
      end else begin
        sc_step    = 0;
        sc_reverse = 1'b0;
      end
      sc_first   = 1'b1;
      sc_due     = '0;
      r.accepted = 1'b1;
    end else if (sc_running) begin
      if (sc_first) begin
        sc_first         = 1'b0;
        r.servo_write    = 1'b1;
        r.servo_position = servo_angle(sc_step);
        sc_due           = it.now_ms + scan_cfg.move_time_ms;
        r.accepted       = 1'b1;
      end else if (it.now_ms >= sc_due) begin
        gap        = it.now_ms - sc_due;
        sc_late    = (gap > 32'hFFFF) ? 16'hFFFF : gap[15:0];
        r.accepted = 1'b1;
        if (it.distance_mm < MinValidMm && sc_retries < scan_cfg.retry_limit) begin
          sc_due     = it.now_ms + scan_cfg.retry_delay_ms;
          sc_retries = sc_retries + 1'b1;
          retried_beats++;
        end else begin
          val = (sc_retries >= scan_cfg.retry_limit) ? 16'h0 : it.distance_mm;
          if (sc_step >= 0 && sc_step < Steps) sc_table[sc_step] = val;
          r.sample_written = 1'b1;
          r.sample_index   = sc_step[3:0];
          r.sample_mm      = val;
          stored_samples++;
          sc_step = sc_reverse ? sc_step - 1 : sc_step + 1;
          sc_due  = it.now_ms + scan_cfg.move_time_ms;
          if ((!sc_reverse && sc_step >= Steps) || (sc_reverse && sc_step < 0)) begin
            sc_running = 1'b0;
            sc_done    = 1'b1;
            finished_sweeps++;
          end else begin
            r.servo_write    = 1'b1;
            r.servo_position = servo_angle(sc_step);
          end
        end
      end
    end
    r.running         = sc_running;
    r.done_res        = sc_done;
    r.retry_count     = sc_retries;
    r.update_delay_ms = sc_late;
    if (it.read_index < Steps) r.read_distance_mm = sc_table[it.read_index];
    return r;
  endfunction

  function automatic item_t make_item(logic m, logic [31:0] t, logic [15:0] d, logic [7:0] ri);
    item_t it;
    it.mode        = m;
    it.now_ms      = t;
    it.distance_mm = d;
    it.read_index  = ri;
    return it;
  endfunction

  function automatic item_t next_scan_item();
    item_t       it;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    it.mode = ((!sc_running && pick < 85) || pick < 2) ? 1'b1 : 1'b0;
    pick    = $urandom_range(0, 99);
    if (pick < 65)      it.now_ms = sc_due + $urandom_range(0, 40);
    else if (pick < 77) it.now_ms = sc_due - $urandom_range(1, 2000);
    else if (pick < 87) it.now_ms = sc_due + $urandom_range(65500, 65600);
    else                it.now_ms = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 25)      it.distance_mm = 16'($urandom_range(0, MinValidMm - 1));
    else if (pick < 30) it.distance_mm = 16'(MinValidMm);
    else if (pick < 35) it.distance_mm = 16'hFFFF;
    else                it.distance_mm = 16'($urandom);
    if ($urandom_range(0, 99) < 75) it.read_index = 8'($urandom_range(0, Steps - 1));
    else                            it.read_index = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic cfg_t make_settings(setting_e kind);
    cfg_t c;
    case (kind)
      SET_FAST_WIDE: begin
        c = '{16'd0, 16'd0, 4'd15, 5'd30, -8'sd90, 7'd90, 6'sd30};
      end
      SET_SLOW_NARROW: begin
        c = '{16'hFFFF, 16'hFFFF, 4'd0, 5'd1, 8'sd0, 7'd0, -6'sd30};
      end
      SET_RANDOM: begin
        c.move_time_ms      = 16'($urandom_range(0, 2000));
        c.retry_delay_ms    = 16'($urandom_range(0, 100));
        c.retry_limit       = 4'($urandom_range(0, 15));
        c.step_angle_deg    = 5'($urandom_range(1, 30));
        c.angle_min_deg     = 8'(-int'($urandom_range(0, 90)));
        c.angle_max_deg     = 7'($urandom_range(0, 90));
        c.center_offset_deg = 6'(int'($urandom_range(0, 60)) - 30);
      end
      SET_RAW: begin
        c = cfg_t'(62'({$urandom, $urandom}));
        c.step_angle_deg = (raw_uses % 2 == 0) ? 5'd0 : 5'd31;
        raw_uses++;
      end
      default: begin
        c = '{MoveTimeRst, RetryDelayRst, RetryLimitRst, StepAngleRst,
              AngleMinRst, AngleMaxRst, CenterOffRst};
      end
    endcase
    return c;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic write_settings(cfg_t c);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(CFG_MOVE_TIME, c.move_time_ms);
    write_reg(CFG_RETRY_DELAY, c.retry_delay_ms);
    write_reg(CFG_RETRY_LIMIT, {junk[15:4], c.retry_limit});
    write_reg(CFG_STEP_ANGLE, {junk[15:5], c.step_angle_deg});
    write_reg(CFG_ANGLE_MIN, {junk[15:8], c.angle_min_deg});
    write_reg(CFG_ANGLE_MAX, {junk[15:7], c.angle_max_deg});
    write_reg(CFG_CENTER_OFFSET, {junk[15:6], c.center_offset_deg});
    cfg_we   <= 1'b0;
    scan_cfg  = c;
  endtask

  task automatic send_beat(item_t it);
    res_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= it.mode;
    now_ms      <= it.now_ms;
    distance_mm <= it.distance_mm;
    read_index  <= it.read_index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = scan_predict(it);
    expected_results.push_back(want);
    sent_beats++;
    if (want.accepted) acted_beats++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_scan_traffic(int unsigned count);
    int unsigned target;
    target = acted_beats + count;
    while (acted_beats < target) send_beat(next_scan_item());
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 22;
    recv_idle_pct = 65;
    send_beat(make_item(1'b0, 32'h0, 16'h0, 8'h00));
    send_beat(make_item(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    send_beat(make_item(1'b0, 32'hFFFF_FF00, 16'h0, 8'h00));
    send_beat(make_item(1'b0, 32'h0000_0010, 16'h1234, 8'h10));
    send_beat(make_item(1'b0, sc_due, 16'd9, 8'h01));
    send_beat(make_item(1'b0, sc_due, 16'd0, 8'h02));
    send_beat(make_item(1'b0, sc_due + 32'd3, 16'd5, 8'h80));
    send_beat(make_item(1'b0, sc_due, 16'd4, 8'h00));
    send_beat(make_item(1'b0, sc_due + 32'd70000, 16'hFFFF, 8'h01));
    send_beat(make_item(1'b1, 32'h0, 16'h0, 8'h0F));
    send_beat(make_item(1'b0, 32'd1000, 16'h5A5A, 8'h00));
    send_beat(make_item(1'b0, sc_due - 32'd1, 16'h7777, 8'h00));
    send_beat(make_item(1'b0, sc_due, 16'hFFFF, 8'h00));
    send_beat(make_item(1'b0, sc_due + 32'd65535, 16'd10, 8'h01));
    while (sc_running) begin
      send_beat(make_item(1'b0, sc_due + 32'd65536, 16'($urandom), 8'($urandom_range(0, 15))));
    end
  endtask

  task automatic test_random_sweeps(int unsigned s_pct, int unsigned r_pct, int unsigned count);
    setting_e kinds [5] = '{SET_DEFAULT, SET_FAST_WIDE, SET_SLOW_NARROW, SET_RANDOM, SET_RAW};
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    foreach (kinds[k]) begin
      settle();
      write_settings(make_settings(kinds[k]));
      run_scan_traffic(count);
    end
  endtask

  task automatic test_output_hold_off();
    settle();
    write_settings(make_settings(SET_RANDOM));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    run_scan_traffic(40);
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_result
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result beat arrived with nothing expected", $time);
      end else begin
        want = expected_results.pop_front();
        compare_field("accepted", want.accepted, accepted);
        compare_field("servo_write", want.servo_write, servo_write);
        compare_field("servo_position", want.servo_position, servo_position);
        compare_field("sample_written", want.sample_written, sample_written);
        compare_field("sample_index", want.sample_index, sample_index);
        compare_field("sample_mm", want.sample_mm, sample_mm);
        compare_field("running", want.running, running);
        compare_field("done_res", want.done_res, done_res);
        compare_field("retry_count", want.retry_count, retry_count);
        compare_field("update_delay_ms", want.update_delay_ms, update_delay_ms);
        compare_field("read_distance_mm", want.read_distance_mm, read_distance_mm);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_results.size());
        $display("[sweep_range_scan_sequencer_top] ERROR");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  initial begin
    scan_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_sweeps(22, 65, 80);
    test_random_sweeps(65, 22, 80);
    test_random_sweeps(0, 0, 80);
    test_output_hold_off();
    settle();
    repeat (DrainCycles) @(posedge clk);
    if (expected_results.size() != 0) errors++;
    $display("Sent %0d beats (%0d acted on) over default, extreme, random and raw settings.",
             sent_beats, acted_beats);
    $display("Stored %0d samples, finished %0d sweeps (%0d backward), %0d retries taken.",
             stored_samples, finished_sweeps, backward_sweeps, retried_beats);
    if (errors == 0) begin
      $display("[sweep_range_scan_sequencer_top] OK");
    end else begin
      $display("[sweep_range_scan_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule
